// ===== design/kstm_pkg.sv =====
`default_nettype none

package kstm_pkg;

    // key matrix geometry
    localparam int NUM_KEYS  = 32;
    localparam int SCAN_W    = 32;
    localparam int TOP_NOTE  = 67;

    // field widths
    localparam int CHAN_W    = 5;
    localparam int CHOFF_W   = 4;
    localparam int TRANS_W   = 7;
    localparam int CFG_W     = 7;
    localparam int NOTE_W    = 7;
    localparam int STATUS_W  = 8;
    localparam int VEL_W     = 7;
    localparam int TDATA_W   = 24;

    // running note value, wide enough for TOP_NOTE + transpose - key index
    localparam int NOTE_ACC_W = 9;

    localparam logic [SCAN_W-1:0] KEY_MASK = {SCAN_W{1'b1}} >> (SCAN_W - NUM_KEYS);

    localparam logic [STATUS_W-1:0]   STATUS_NOTE_OFF = 8'h80;
    localparam logic [STATUS_W-1:0]   STATUS_NOTE_ON  = 8'h90;
    localparam logic [VEL_W-1:0]      VELOCITY        = 7'h40;
    localparam logic [NOTE_W-1:0]     NOTE_MAX        = 7'd127;
    localparam logic [CHAN_W-1:0]     CHAN_RESET      = 5'd1;
    localparam logic [CHAN_W-1:0]     CHAN_TOP        = 5'd16;
    localparam logic [CHOFF_W-1:0]    CHOFF_TOP       = 4'd15;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_MIDI_CHANNEL = 1'b0,
        CFG_TRANSPOSE    = 1'b1
    } t_cfg_reg;

    // scan walker states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } t_walk_state;

    // per-cycle step from walker to message stage
    typedef struct packed {
        logic start;     // new scan loaded, restart note count
        logic advance;   // one key position consumed
        logic emit;      // a message leaves for this key
        logic released;  // key now released (note off)
        logic last;      // no further changed key in this scan
    } t_step;

endpackage

`default_nettype wire

// ===== design/kstm_cfg_regs.sv =====
`default_nettype none

module kstm_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire kstm_pkg::t_cfg_reg            i_cfg_addr,
    input  wire logic [kstm_pkg::CFG_W-1:0]    i_cfg_data,
    output logic [kstm_pkg::CHOFF_W-1:0]       o_chan_off,
    output logic signed [kstm_pkg::TRANS_W-1:0] o_transpose
);
    import kstm_pkg::*;

    logic [CHAN_W-1:0]  r_channel;
    logic [TRANS_W-1:0] r_transpose;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel   <= CHAN_RESET;
            r_transpose <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MIDI_CHANNEL: r_channel   <= i_cfg_data[CHAN_W-1:0];
                CFG_TRANSPOSE:    r_transpose <= i_cfg_data[TRANS_W-1:0];
                default: ;
            endcase
        end
    end

    // channel 0 acts as 1, above 16 saturates to 16
    always_comb begin
        if (r_channel == '0) begin
            o_chan_off = '0;
        end else if (r_channel > CHAN_TOP) begin
            o_chan_off = CHOFF_TOP;
        end else begin
            o_chan_off = CHOFF_W'(r_channel - CHAN_W'(1));
        end
    end

    assign o_transpose = signed'(r_transpose);

endmodule

`default_nettype wire

// ===== design/kstm_walker.sv =====
`default_nettype none

module kstm_walker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [kstm_pkg::SCAN_W-1:0]  i_scan,
    input  wire logic                         i_slot_free,
    output kstm_pkg::t_step                   o_step
);
    import kstm_pkg::*;

    t_walk_state       r_state, n_state;
    logic [SCAN_W-1:0] r_key;
    logic [SCAN_W-1:0] r_diff;
    logic [SCAN_W-1:0] r_scan;
    logic              accept;
    logic              advance;

    assign accept  = i_valid && o_ready;
    assign advance = (r_state == ST_WALK) && (r_diff != '0) && (!r_diff[0] || i_slot_free);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_WALK;
            ST_WALK: if (r_diff == '0) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready          = 1'b0;
        o_step.start     = 1'b0;
        o_step.advance   = 1'b0;
        o_step.emit      = 1'b0;
        o_step.released  = r_scan[0];
        o_step.last      = (r_diff >> 1) == '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_step.start = i_valid;
            end
            ST_WALK: begin
                o_step.advance = advance;
                o_step.emit    = advance && r_diff[0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // key state takes new scan; changes walk one bit a cycle unless stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_diff <= '0;
        end else if (accept) begin
            r_key  <= i_scan & KEY_MASK;
            r_diff <= (i_scan ^ r_key) & KEY_MASK;
        end else if (advance) begin
            r_diff <= r_diff >> 1;
        end
    end

    // scan level shifter, payload only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_scan <= i_scan;
        end else if (advance) begin
            r_scan <= r_scan >> 1;
        end
    end

    a_accept_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_WALK))
        else $error("scan accepted but walker not running");

    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WALK) && (r_diff == '0)) |=> (r_state == ST_IDLE))
        else $error("walker did not finish after last change");

    a_key_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_key))
        else $error("key state changed without a scan");

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step.emit |-> i_slot_free)
        else $error("message emitted into a full output stage");

endmodule

`default_nettype wire

// ===== design/kstm_msg_out.sv =====
`default_nettype none

module kstm_msg_out (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire kstm_pkg::t_step                   i_step,
    input  wire logic [kstm_pkg::CHOFF_W-1:0]      i_chan_off,
    input  wire logic signed [kstm_pkg::TRANS_W-1:0] i_transpose,
    output logic                                   o_slot_free,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [kstm_pkg::STATUS_W-1:0]          o_status,
    output logic [kstm_pkg::NOTE_W-1:0]            o_note,
    output logic [kstm_pkg::VEL_W-1:0]             o_velocity,
    output logic                                   o_last
);
    import kstm_pkg::*;

    logic signed [NOTE_ACC_W-1:0] r_note_acc;
    logic [NOTE_W-1:0]            note_clamped;
    logic [STATUS_W-1:0]          status_base;
    logic                         r_valid;
    logic [STATUS_W-1:0]          r_status;
    logic [NOTE_W-1:0]            r_note;
    logic                         r_last;

    // note for the current key position, counts down one per key
    always_ff @(posedge i_clk) begin
        if (i_step.start) begin
            r_note_acc <= NOTE_ACC_W'(TOP_NOTE) + NOTE_ACC_W'(i_transpose);
        end else if (i_step.advance) begin
            r_note_acc <= r_note_acc - NOTE_ACC_W'(1);
        end
    end

    // clamp into the midi note range
    always_comb begin
        if (r_note_acc < 0) begin
            note_clamped = '0;
        end else if (r_note_acc > signed'(NOTE_ACC_W'(NOTE_MAX))) begin
            note_clamped = NOTE_MAX;
        end else begin
            note_clamped = r_note_acc[NOTE_W-1:0];
        end
    end

    assign status_base = i_step.released ? STATUS_NOTE_OFF : STATUS_NOTE_ON;
    assign o_slot_free = !r_valid || i_ready;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.emit) begin
            r_status <= status_base + STATUS_W'(i_chan_off);
            r_note   <= note_clamped;
            r_last   <= i_step.last;
        end
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_note     = r_note;
    assign o_velocity = VELOCITY;
    assign o_last     = r_last;

endmodule

`default_nettype wire

// ===== design/key_scan_to_midi_events_unit.sv =====
`default_nettype none

// Turns each 32-bit scan of an active-low key matrix (1 released, 0 pressed)
// into MIDI note messages, one for every key that changed since the previous
// scan, lowest key first: note off when released, note on when pressed, note
// 67 - key + transpose clamped to 0..127, velocity 64, tlast on the final
// message of the scan. After reset the stored state is all zero, so the first
// scan reports a note off for every released key. Once a scan is taken, the
// change word is shifted out one key per cycle up to the highest changed key,
// holding while a changed key waits on a full output register. The next scan
// is accepted once the walk has finished, even while the last message still
// waits in the output register. Config index 0 is the channel (1..16, 0 acts
// as 1, above 16 as 16), index 1 the signed transpose; write them only while
// idle.
module key_scan_to_midi_events_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [kstm_pkg::SCAN_W-1:0]       s_axis_tdata,  // [31:0] scan_word
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] status_byte, [14:8] note_byte, [21:15] velocity_byte, [23:22] zero
    output logic [kstm_pkg::TDATA_W-1:0]           m_axis_tdata,
    output logic                                   m_axis_tlast,  // last_event
    input  wire logic                              i_cfg_we,
    input  wire kstm_pkg::t_cfg_reg                i_cfg_addr,
    input  wire logic [kstm_pkg::CFG_W-1:0]        i_cfg_data
);
    import kstm_pkg::*;

    logic [CHOFF_W-1:0]        chan_off;
    logic signed [TRANS_W-1:0] transpose;
    t_step                     step;
    logic                      slot_free;
    logic [STATUS_W-1:0]       status;
    logic [NOTE_W-1:0]         note;
    logic [VEL_W-1:0]          velocity;

    kstm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_chan_off  (chan_off),
        .o_transpose (transpose)
    );

    kstm_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_scan      (s_axis_tdata),
        .i_slot_free (slot_free),
        .o_step      (step)
    );

    kstm_msg_out u_msg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_chan_off  (chan_off),
        .i_transpose (transpose),
        .o_slot_free (slot_free),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (status),
        .o_note      (note),
        .o_velocity  (velocity),
        .o_last      (m_axis_tlast)
    );

    // pack message fields, lowest field first
    assign m_axis_tdata = {2'b00, velocity, note, status};

endmodule

`default_nettype wire

// ===== bench/key_scan_to_midi_events_unit_tb.sv =====
module key_scan_to_midi_events_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kstm_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_CYCLES  = 40;    // longest walk plus output register
    localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int RAND_ITEMS    = 500;
    localparam int PHASES        = 5;

    // one expected midi message
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NOTE_W-1:0]   note;
        logic [VEL_W-1:0]    velocity;
        logic                last;
    } t_midi_msg;

    // directed stimulus rows
    typedef enum logic {
        ROW_SCAN = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        t_cfg_reg            cfg_sel;
        logic [CFG_W-1:0]    value;
        logic [SCAN_W-1:0]   scan;
        logic                typed;     // expectation written out below
        logic [1:0]          exp_n;     // 0 or 1 message
        logic [STATUS_W-1:0] exp_status;
        logic [NOTE_W-1:0]   exp_note;
    } t_row;

    localparam int N_DIR = 27;
    localparam t_row DIR_ROWS [N_DIR] = '{
        // first scan after reset: key 0 released
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'h0000_0001, 1'b1, 2'd1, STATUS_NOTE_OFF, 7'd67},
        // same scan again, nothing changes
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'h0000_0001, 1'b1, 2'd0, 8'h00, 7'd0},
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'h0000_0000, 1'b1, 2'd1, STATUS_NOTE_ON, 7'd67},
        // every key at once, both directions
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'hFFFF_FFFF, 1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'h0000_0000, 1'b0, 2'd0, 8'h00, 7'd0},
        // top key only
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'h8000_0000, 1'b1, 2'd1, STATUS_NOTE_OFF, 7'd36},
        // highest channel, highest transpose: low keys clamp at 127
        '{ROW_CFG,  CFG_MIDI_CHANNEL, 7'd16, 32'h0,         1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_CFG,  CFG_TRANSPOSE,    7'h3F, 32'h0,         1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'h7FFF_FFFF, 1'b0, 2'd0, 8'h00, 7'd0},
        // channel zero acts as one, lowest transpose clamps top key at 0
        '{ROW_CFG,  CFG_MIDI_CHANNEL, 7'd0,  32'h0,         1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_CFG,  CFG_TRANSPOSE,    7'h40, 32'h0,         1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'hFFFF_FFFF, 1'b1, 2'd1, STATUS_NOTE_OFF, 7'd0},
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'h5555_5555, 1'b0, 2'd0, 8'h00, 7'd0},
        // channel above 16 saturates
        '{ROW_CFG,  CFG_MIDI_CHANNEL, 7'd31, 32'h0,         1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_CFG,  CFG_TRANSPOSE,    7'h7F, 32'h0,         1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'hAAAA_AAAA, 1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_CFG,  CFG_MIDI_CHANNEL, 7'd17, 32'h0,         1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_CFG,  CFG_TRANSPOSE,    7'h01, 32'h0,         1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'h0000_0000, 1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_CFG,  CFG_MIDI_CHANNEL, 7'd10, 32'h0,         1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_CFG,  CFG_TRANSPOSE,    7'h20, 32'h0,         1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'h1234_5678, 1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'hFFFF_0000, 1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_CFG,  CFG_MIDI_CHANNEL, 7'd1,  32'h0,         1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_CFG,  CFG_TRANSPOSE,    7'h00, 32'h0,         1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'h0000_FFFF, 1'b0, 2'd0, 8'h00, 7'd0},
        '{ROW_SCAN, CFG_MIDI_CHANNEL, 7'd0,  32'h0000_FFFF, 1'b1, 2'd0, 8'h00, 7'd0}
    };

    // dut signals
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [SCAN_W-1:0]     s_axis_tdata   = '0;  // [31:0] scan_word
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    // [7:0] status_byte, [14:8] note_byte, [21:15] velocity_byte, [23:22] zero
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  m_axis_tlast;         // last_event
    logic                  i_cfg_we       = 1'b0;
    t_cfg_reg              i_cfg_addr     = CFG_MIDI_CHANNEL;
    logic [CFG_W-1:0]      i_cfg_data     = '0;

    // mirror of the block: key levels and settings
    logic [SCAN_W-1:0]     held_keys      = '0;
    logic [CHAN_W-1:0]     cur_channel    = CHAN_RESET;
    logic signed [TRANS_W-1:0] cur_transpose = '0;

    t_midi_msg             midi_expect[$];
    int                    errors         = 0;
    int                    sink_hold      = 0;
    bit                    src_idle_en    = 1'b1;
    bit                    sink_idle_en   = 1'b1;
    int                    quiet_cycles   = 0;

    key_scan_to_midi_events_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // note events for one scan, lowest key first; updates the key levels
    function automatic void advance_keys(input logic [SCAN_W-1:0] scan, input bit queue_it);
        logic [SCAN_W-1:0]  changed;
        logic [CHAN_W-1:0]  ch;
        logic [CHOFF_W-1:0] ch_off;
        int                 pitch;
        int                 top_changed;
        t_midi_msg          msg;
        changed = (scan ^ held_keys) & KEY_MASK;
        ch = cur_channel;
        if (ch == '0) ch = CHAN_RESET;
        if (ch > CHAN_TOP) ch = CHAN_TOP;
        ch_off = CHOFF_W'(ch - 5'd1);
        top_changed = -1;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (changed[k]) top_changed = k;
        end
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (changed[k]) begin
                pitch = TOP_NOTE - k + int'(cur_transpose);
                if (pitch < 0) pitch = 0;
                if (pitch > int'(NOTE_MAX)) pitch = int'(NOTE_MAX);
                msg.status   = (scan[k] ? STATUS_NOTE_OFF : STATUS_NOTE_ON) | {4'd0, ch_off};
                msg.note     = NOTE_W'(pitch);
                msg.velocity = VELOCITY;
                msg.last     = (k == top_changed);
                if (queue_it) midi_expect.push_back(msg);
            end
        end
        held_keys = held_keys ^ changed;
    endfunction

    // present one scan, wait for the handshake, record what it should cause
    task automatic send_scan(input logic [SCAN_W-1:0] scan, input logic typed,
                             input logic [1:0] exp_n, input logic [STATUS_W-1:0] exp_status,
                             input logic [NOTE_W-1:0] exp_note);
        int gap;
        @(negedge i_clk);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= scan;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        advance_keys(scan, !typed);
        if (typed && exp_n == 2'd1)
            midi_expect.push_back('{exp_status, exp_note, VELOCITY, 1'b1});
    endtask

    // register write once the block has gone quiet
    task automatic write_cfg(input t_cfg_reg sel, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (midi_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= sel;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (sel)
            CFG_MIDI_CHANNEL: cur_channel   = value[CHAN_W-1:0];
            CFG_TRANSPOSE:    cur_transpose = value;
            default: ;
        endcase
    endtask

    // output back-pressure in bursts
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            sink_hold = $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each message with the oldest expectation
    always @(posedge i_clk) begin : check_msgs
        t_midi_msg want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (midi_expect.size() == 0) begin
                $error("unexpected message: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                want = midi_expect.pop_front();
                if (m_axis_tdata[7:0] !== want.status) begin
                    $error("status_byte: expected %h, got %h", want.status, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[14:8] !== want.note) begin
                    $error("note_byte: expected %0d, got %0d", want.note, m_axis_tdata[14:8]);
                    errors++;
                end
                if (m_axis_tdata[21:15] !== want.velocity) begin
                    $error("velocity_byte: expected %0d, got %0d",
                           want.velocity, m_axis_tdata[21:15]);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_event: expected %b, got %b", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus
    initial begin : stim
        t_row          row;
        logic [SCAN_W-1:0] scan;
        int            counted;
        int            pick;
        int            flips;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        for (int r = 0; r < N_DIR; r++) begin
            row = DIR_ROWS[r];
            if (row.kind == ROW_CFG)
                write_cfg(row.cfg_sel, row.value);
            else
                send_scan(row.scan, row.typed, row.exp_n, row.exp_status, row.exp_note);
        end

        // random phases, each with fresh settings; the last one runs without idling
        counted = 0;
        for (int p = 0; p < PHASES; p++) begin
            write_cfg(CFG_MIDI_CHANNEL, CFG_W'($urandom_range(0, 31)));
            write_cfg(CFG_TRANSPOSE, CFG_W'($urandom_range(0, 127)));
            src_idle_en  = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_idle_en = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            while (counted < (p + 1) * (RAND_ITEMS / PHASES)) begin
                pick = $urandom_range(0, 99);
                scan = held_keys;
                if (pick < 55) begin
                    // a few keys pressed or released, as a player would
                    flips = $urandom_range(1, 3);
                    repeat (flips) scan[$urandom_range(0, NUM_KEYS - 1)] ^= 1'b1;
                end else if (pick < 75) begin
                    scan = $urandom();
                end else if (pick < 85) begin
                    scan = held_keys;
                end else if (pick < 93) begin
                    scan = ~held_keys;
                end else begin
                    scan = ($urandom_range(0, 1) == 0) ? '0 : '1;
                end
                if (((scan ^ held_keys) & KEY_MASK) != '0) counted++;
                send_scan(scan, 1'b0, 2'd0, 8'h00, 7'd0);
            end
        end

        // drain
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (midi_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && midi_expect.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
